FILE: rtl/core/ookpw_pkg.sv
// types and constants shared by the ook pulse-width code transmitter
package ookpw_pkg;

    localparam int unsigned CODE_W  = 64;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned TICKS_W = 24;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MULT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MULT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_HIGH_MULT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LOW_MULT  = 3'd5;

    // register values after reset
    localparam logic [15:0] RST_PULSE_LENGTH   = 16'd350;
    localparam logic [7:0]  RST_LONG_MULT      = 8'd3;
    localparam logic [7:0]  RST_SHORT_MULT     = 8'd1;
    localparam logic [7:0]  RST_REPEAT_COUNT   = 8'd10;
    localparam logic [7:0]  RST_SYNC_HIGH_MULT = 8'd1;
    localparam logic [7:0]  RST_SYNC_LOW_MULT  = 8'd31;

    // item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BIT_HIGH,
        PH_BIT_LOW,
        PH_SYNC_HIGH,
        PH_SYNC_LOW
    } t_phase;

    typedef struct packed {
        logic               kind;
        logic [CODE_W-1:0]  code;
        logic [COUNT_W-1:0] bit_count;
    } t_in_item;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } t_out_item;

endpackage

FILE: rtl/core/ook_pulse_width_code_transmitter_core.sv
// ook pulse-width remote code transmitter: input register, segment sequencer, result register
// an accepted item is held in the input register, its result item in the result register
// throughput: one item per cycle while not stalled; the path is a tick decrement, a phase
// step and one 16x8 multiply for the next segment length, all between the two registers
// reset: synchronous, active low; sequencer idle, line low, registers at their default values
// configuration writes are always accepted; indexes beyond the register list are ignored
module ook_pulse_width_code_transmitter_core #(
    parameter int unsigned MAX_BITS = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // item input channel
    input  logic                                 i_valid,
    input  ookpw_pkg::t_in_item                  i_item,
    output logic                                 o_stall,
    // result channel
    output logic                                 o_valid,
    output ookpw_pkg::t_out_item                 o_result,
    input  logic                                 i_stall,
    // configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ookpw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ookpw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // width of the held bit count and of the bit index into the held code
    localparam int unsigned CW = $clog2(MAX_BITS + 1);
    localparam int unsigned IW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

    // configuration registers
    logic [15:0] r_pulse;
    logic [7:0]  r_long_mult;
    logic [7:0]  r_short_mult;
    logic [7:0]  r_repeat;
    logic [7:0]  r_sync_high_mult;
    logic [7:0]  r_sync_low_mult;

    // input register
    logic                r_in_valid;
    ookpw_pkg::t_in_item r_in;

    // sequencer state
    ookpw_pkg::t_phase                  r_phase, n_phase;
    logic                               r_level, n_level;
    logic [MAX_BITS-1:0]                r_code, n_code;
    logic [CW-1:0]                      r_count, n_count;
    logic [CW-1:0]                      r_bits, n_bits;
    logic [7:0]                         r_frames, n_frames;
    logic [ookpw_pkg::TICKS_W-1:0]      r_ticks, n_ticks;

    // result register
    logic                 r_out_valid;
    ookpw_pkg::t_out_item r_out, n_out;

    // segment length set-up
    logic                               seg_start;
    logic [7:0]                         seg_mult;
    logic [ookpw_pkg::TICKS_W-1:0]      seg_prod;
    logic                               done;

    // pipeline moves when the result register is free or being taken
    logic en;

    // picks the bit sent when n bits are still left
    function automatic logic f_bit(input logic [MAX_BITS-1:0] c, input logic [CW-1:0] n);
        logic [IW-1:0] idx;
        idx = IW'(n - 1'b1);
        return c[idx];
    endfunction

    assign en          = !r_out_valid || !i_stall;
    assign o_stall     = r_in_valid && !en;
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;
    assign o_cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse          <= ookpw_pkg::RST_PULSE_LENGTH;
            r_long_mult      <= ookpw_pkg::RST_LONG_MULT;
            r_short_mult     <= ookpw_pkg::RST_SHORT_MULT;
            r_repeat         <= ookpw_pkg::RST_REPEAT_COUNT;
            r_sync_high_mult <= ookpw_pkg::RST_SYNC_HIGH_MULT;
            r_sync_low_mult  <= ookpw_pkg::RST_SYNC_LOW_MULT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ookpw_pkg::CFG_PULSE_LENGTH:   r_pulse          <= i_cfg_data;
                ookpw_pkg::CFG_LONG_MULT:      r_long_mult      <= i_cfg_data[7:0];
                ookpw_pkg::CFG_SHORT_MULT:     r_short_mult     <= i_cfg_data[7:0];
                ookpw_pkg::CFG_REPEAT_COUNT:   r_repeat         <= i_cfg_data[7:0];
                ookpw_pkg::CFG_SYNC_HIGH_MULT: r_sync_high_mult <= i_cfg_data[7:0];
                ookpw_pkg::CFG_SYNC_LOW_MULT:  r_sync_low_mult  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // input register: loads when empty or when its item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in <= i_item;
        end
    end

    // next state of the sequencer for the item in the input register
    always_comb begin
        logic [7:0]                    frames_dec;
        logic [CW-1:0]                 bits_dec;
        logic [CW-1:0]                 sat_count;
        logic [MAX_BITS-1:0]           in_code;
        logic [ookpw_pkg::TICKS_W-1:0] ticks_dec;

        n_phase   = r_phase;
        n_level   = r_level;
        n_code    = r_code;
        n_count   = r_count;
        n_bits    = r_bits;
        n_frames  = r_frames;
        n_ticks   = r_ticks;
        seg_start = 1'b0;
        seg_mult  = r_sync_high_mult;
        done      = 1'b0;

        in_code    = r_in.code[MAX_BITS-1:0];
        sat_count  = (r_in.bit_count > 7'(MAX_BITS)) ? CW'(MAX_BITS) : CW'(r_in.bit_count);
        ticks_dec  = (r_ticks != '0) ? r_ticks - 1'b1 : r_ticks;
        bits_dec   = (r_bits != '0) ? r_bits - 1'b1 : r_bits;
        frames_dec = (r_frames != '0) ? r_frames - 1'b1 : r_frames;

        if (r_in.kind == ookpw_pkg::KIND_START) begin
            // a start while busy or with no frames to send changes nothing
            if (r_phase == ookpw_pkg::PH_IDLE && r_repeat != '0) begin
                n_code    = in_code;
                n_count   = sat_count;
                n_bits    = sat_count;
                n_frames  = r_repeat;
                n_level   = 1'b1;
                seg_start = 1'b1;
                if (sat_count != '0) begin
                    n_phase  = ookpw_pkg::PH_BIT_HIGH;
                    seg_mult = f_bit(in_code, sat_count) ? r_long_mult : r_short_mult;
                end else begin
                    n_phase  = ookpw_pkg::PH_SYNC_HIGH;
                    seg_mult = r_sync_high_mult;
                end
            end
        end else if (r_phase != ookpw_pkg::PH_IDLE) begin
            n_ticks = ticks_dec;
            if (ticks_dec == '0) begin
                unique case (r_phase)
                    ookpw_pkg::PH_BIT_HIGH: begin
                        n_phase   = ookpw_pkg::PH_BIT_LOW;
                        n_level   = 1'b0;
                        seg_start = 1'b1;
                        seg_mult  = f_bit(r_code, r_bits) ? r_short_mult : r_long_mult;
                    end
                    ookpw_pkg::PH_BIT_LOW: begin
                        n_bits    = bits_dec;
                        n_level   = 1'b1;
                        seg_start = 1'b1;
                        if (bits_dec != '0) begin
                            n_phase  = ookpw_pkg::PH_BIT_HIGH;
                            seg_mult = f_bit(r_code, bits_dec) ? r_long_mult : r_short_mult;
                        end else begin
                            n_phase  = ookpw_pkg::PH_SYNC_HIGH;
                            seg_mult = r_sync_high_mult;
                        end
                    end
                    ookpw_pkg::PH_SYNC_HIGH: begin
                        n_phase   = ookpw_pkg::PH_SYNC_LOW;
                        n_level   = 1'b0;
                        seg_start = 1'b1;
                        seg_mult  = r_sync_low_mult;
                    end
                    default: begin
                        // end of a frame's sync low
                        n_frames = frames_dec;
                        if (frames_dec == '0) begin
                            n_phase = ookpw_pkg::PH_IDLE;
                            n_level = 1'b0;
                            n_ticks = '0;
                            n_bits  = '0;
                            done    = 1'b1;
                        end else begin
                            n_bits    = r_count;
                            n_level   = 1'b1;
                            seg_start = 1'b1;
                            if (r_count != '0) begin
                                n_phase  = ookpw_pkg::PH_BIT_HIGH;
                                seg_mult = f_bit(r_code, r_count) ? r_long_mult
                                                                  : r_short_mult;
                            end else begin
                                n_phase  = ookpw_pkg::PH_SYNC_HIGH;
                                seg_mult = r_sync_high_mult;
                            end
                        end
                    end
                endcase
            end
        end

        // new segment length, a zero product lasts one tick
        seg_prod = ookpw_pkg::TICKS_W'(r_pulse) * ookpw_pkg::TICKS_W'(seg_mult);
        if (seg_start) begin
            n_ticks = (seg_prod != '0) ? seg_prod : ookpw_pkg::TICKS_W'(1);
        end
    end

    // result item for the item being processed
    always_comb begin
        n_out.line_level = n_level;
        n_out.busy_res   = (n_phase != ookpw_pkg::PH_IDLE);
        n_out.frame_done = done;
    end

    // sequencer state, updated once per processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ookpw_pkg::PH_IDLE;
            r_level  <= 1'b0;
            r_count  <= '0;
            r_bits   <= '0;
            r_frames <= '0;
            r_ticks  <= '0;
        end else if (en && r_in_valid) begin
            r_phase  <= n_phase;
            r_level  <= n_level;
            r_count  <= n_count;
            r_bits   <= n_bits;
            r_frames <= n_frames;
            r_ticks  <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_in_valid) begin
            r_code <= n_code;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_in_valid) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the ook pulse-width code transmitter core
module tb_top;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned IDLE_PCT       = 32;
    localparam int unsigned RUN_OUT_BATCH  = 16;
    localparam logic [ookpw_pkg::COUNT_W-1:0] MAX_COUNT = 7'd64;

    // indexes past the register list, writes there must change nothing
    localparam logic [ookpw_pkg::CFG_IDX_W-1:0] CFG_NO_REG_LO = 3'd6;
    localparam logic [ookpw_pkg::CFG_IDX_W-1:0] CFG_NO_REG_HI = 3'd7;

    logic                             i_clk       = 1'b0;
    logic                             i_rst_n     = 1'b0;
    logic                             i_valid     = 1'b0;
    ookpw_pkg::t_in_item              i_item      = '0;
    logic                             o_stall;
    logic                             o_valid;
    ookpw_pkg::t_out_item             o_result;
    logic                             i_stall     = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [ookpw_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [ookpw_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    ook_pulse_width_code_transmitter_core #(
        .MAX_BITS(64)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_item     (i_item),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_stall    (i_stall),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 0;
    end

    // ------------------------------------------------------------------
    // line encoder mirror: registers and sequencer state
    // ------------------------------------------------------------------
    logic [15:0]        pulse_len = ookpw_pkg::RST_PULSE_LENGTH;
    logic [7:0]         long_m    = ookpw_pkg::RST_LONG_MULT;
    logic [7:0]         short_m   = ookpw_pkg::RST_SHORT_MULT;
    logic [7:0]         repeats   = ookpw_pkg::RST_REPEAT_COUNT;
    logic [7:0]         sync_hi_m = ookpw_pkg::RST_SYNC_HIGH_MULT;
    logic [7:0]         sync_lo_m = ookpw_pkg::RST_SYNC_LOW_MULT;

    ookpw_pkg::t_phase                  tx_phase       = ookpw_pkg::PH_IDLE;
    logic                               tx_level       = 1'b0;
    logic [ookpw_pkg::CODE_W-1:0]       tx_code        = '0;
    logic [ookpw_pkg::COUNT_W-1:0]      tx_count       = '0;
    logic [ookpw_pkg::COUNT_W-1:0]      tx_bits_left   = '0;
    logic [7:0]                         tx_frames_left = '0;
    logic [ookpw_pkg::TICKS_W-1:0]      tx_ticks_left  = '0;

    // segment length in ticks; a zero product still lasts one tick
    function automatic logic [ookpw_pkg::TICKS_W-1:0] seg_ticks(input logic [7:0] mult);
        logic [31:0] prod;
        prod = {16'd0, pulse_len} * {24'd0, mult};
        if (prod == 32'd0) prod = 32'd1;
        return prod[ookpw_pkg::TICKS_W-1:0];
    endfunction

    // bit now on the line, counted from the top of the held bits
    function automatic logic code_bit();
        logic [ookpw_pkg::COUNT_W-1:0] idx;
        idx = tx_bits_left - 7'd1;
        return tx_code[idx[5:0]];
    endfunction

    function automatic void open_bit();
        tx_phase      = ookpw_pkg::PH_BIT_HIGH;
        tx_level      = 1'b1;
        tx_ticks_left = seg_ticks(code_bit() ? long_m : short_m);
    endfunction

    function automatic void open_sync();
        tx_phase      = ookpw_pkg::PH_SYNC_HIGH;
        tx_level      = 1'b1;
        tx_ticks_left = seg_ticks(sync_hi_m);
    endfunction

    function automatic void open_frame();
        tx_bits_left = tx_count;
        if (tx_bits_left != 0) open_bit();
        else open_sync();
    endfunction

    // end of the running segment, high when the last frame has gone out
    function automatic logic close_segment();
        case (tx_phase)
            ookpw_pkg::PH_BIT_HIGH: begin
                tx_phase      = ookpw_pkg::PH_BIT_LOW;
                tx_level      = 1'b0;
                tx_ticks_left = seg_ticks(code_bit() ? short_m : long_m);
            end
            ookpw_pkg::PH_BIT_LOW: begin
                if (tx_bits_left != 0) tx_bits_left--;
                if (tx_bits_left != 0) open_bit();
                else open_sync();
            end
            ookpw_pkg::PH_SYNC_HIGH: begin
                tx_phase      = ookpw_pkg::PH_SYNC_LOW;
                tx_level      = 1'b0;
                tx_ticks_left = seg_ticks(sync_lo_m);
            end
            default: begin
                if (tx_frames_left != 0) tx_frames_left--;
                if (tx_frames_left == 0) begin
                    tx_phase      = ookpw_pkg::PH_IDLE;
                    tx_level      = 1'b0;
                    tx_ticks_left = '0;
                    tx_bits_left  = '0;
                    return 1'b1;
                end
                open_frame();
            end
        endcase
        return 1'b0;
    endfunction

    // line state after one accepted item
    function automatic ookpw_pkg::t_out_item ook_step(input ookpw_pkg::t_in_item it);
        ookpw_pkg::t_out_item res;
        logic                 done;
        done = 1'b0;
        if (it.kind == ookpw_pkg::KIND_START) begin
            // a start while frames are going out is dropped
            if (tx_phase == ookpw_pkg::PH_IDLE && repeats != 8'd0) begin
                tx_code        = it.code;
                tx_count       = (it.bit_count > MAX_COUNT) ? MAX_COUNT : it.bit_count;
                tx_frames_left = repeats;
                open_frame();
            end
        end else if (tx_phase != ookpw_pkg::PH_IDLE) begin
            if (tx_ticks_left != 0) tx_ticks_left--;
            if (tx_ticks_left == 0) done = close_segment();
        end
        res.line_level = tx_level;
        res.busy_res   = (tx_phase != ookpw_pkg::PH_IDLE);
        res.frame_done = done;
        return res;
    endfunction

    function automatic void apply_reg(input logic [ookpw_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [ookpw_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            ookpw_pkg::CFG_PULSE_LENGTH:   pulse_len = val;
            ookpw_pkg::CFG_LONG_MULT:      long_m    = val[7:0];
            ookpw_pkg::CFG_SHORT_MULT:     short_m   = val[7:0];
            ookpw_pkg::CFG_REPEAT_COUNT:   repeats   = val[7:0];
            ookpw_pkg::CFG_SYNC_HIGH_MULT: sync_hi_m = val[7:0];
            ookpw_pkg::CFG_SYNC_LOW_MULT:  sync_lo_m = val[7:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // item queues and shared flags
    // ------------------------------------------------------------------
    ookpw_pkg::t_in_item  tx_items[$];       // items waiting to be offered
    ookpw_pkg::t_out_item want_levels[$];    // predicted line states, oldest first
    int unsigned n_queued    = 0;
    int unsigned n_taken     = 0;
    int unsigned errors      = 0;
    logic        steady      = 1'b0;    // no idling on either side
    logic        squeeze_arm = 1'b0;    // ask the receiver for one long hold-off

    function automatic logic [ookpw_pkg::CODE_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_item(input logic kind,
                                       input logic [ookpw_pkg::CODE_W-1:0] code,
                                       input logic [ookpw_pkg::COUNT_W-1:0] cnt);
        ookpw_pkg::t_in_item it;
        it.kind      = kind;
        it.code      = code;
        it.bit_count = cnt;
        tx_items.push_back(it);
        n_queued++;
    endfunction

    // tick with junk in the unused fields
    function automatic void queue_tick();
        queue_item(ookpw_pkg::KIND_TICK, rand64(), 7'($urandom));
    endfunction

    task automatic settle();
        while (n_taken != n_queued) @(posedge i_clk);
    endtask

    // every item taken, every result back, then the pipeline is left to drain
    task automatic quiesce();
        while (n_taken != n_queued || want_levels.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [ookpw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ookpw_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, val);
    endtask

    // upper byte of the 8-bit registers gets junk, it must be dropped
    task automatic load_regs(input logic [15:0] pl, input logic [7:0] lm, sm, rc, sh, sl);
        quiesce();
        cfg_write(ookpw_pkg::CFG_PULSE_LENGTH, pl);
        cfg_write(ookpw_pkg::CFG_LONG_MULT, {8'($urandom), lm});
        cfg_write(ookpw_pkg::CFG_SHORT_MULT, {8'($urandom), sm});
        cfg_write(ookpw_pkg::CFG_REPEAT_COUNT, {8'($urandom), rc});
        cfg_write(ookpw_pkg::CFG_SYNC_HIGH_MULT, {8'($urandom), sh});
        cfg_write(ookpw_pkg::CFG_SYNC_LOW_MULT, {8'($urandom), sl});
        cfg_write(CFG_NO_REG_LO, 16'($urandom));
        cfg_write(CFG_NO_REG_HI, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // feed ticks until the mirror says the last frame is out
    task automatic run_out();
        do begin
            repeat (RUN_OUT_BATCH) queue_tick();
            settle();
        end while (tx_phase != ookpw_pkg::PH_IDLE);
    endtask

    // ------------------------------------------------------------------
    // driver: offers queued items, holds a stalled item unchanged
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                want_levels.push_back(ook_step(i_item));
                n_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (tx_items.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    i_valid <= 1'b1;
                    i_item  <= tx_items.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result item, drives the result stall
    // ------------------------------------------------------------------
    ookpw_pkg::t_out_item want_now;
    logic                 squeezed  = 1'b0;
    int unsigned          hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (want_levels.size() == 0) begin
                    $error("result item with nothing expected: %p", o_result);
                    errors++;
                end else begin
                    want_now = want_levels.pop_front();
                    if (o_result.line_level !== want_now.line_level) begin
                        $error("line_level: expected %0b, got %0b",
                               want_now.line_level, o_result.line_level);
                        errors++;
                    end
                    if (o_result.busy_res !== want_now.busy_res) begin
                        $error("busy_res: expected %0b, got %0b",
                               want_now.busy_res, o_result.busy_res);
                        errors++;
                    end
                    if (o_result.frame_done !== want_now.frame_done) begin
                        $error("frame_done: expected %0b, got %0b",
                               want_now.frame_done, o_result.frame_done);
                        errors++;
                    end
                end
            end
            // one long hold-off so the core fills up and stalls its input
            if (hold_left != 0) begin
                i_stall   <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (squeeze_arm && !squeezed) begin
                squeezed  <= 1'b1;
                hold_left <= HOLD_CYCLES;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // watchdog on cycles with no handshake of any kind
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int unsigned k;
        int unsigned n;
        int unsigned pass_no;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: idle tick, sync-only start, start while busy
        queue_tick();
        queue_item(ookpw_pkg::KIND_START, '1, 7'd0);
        queue_item(ookpw_pkg::KIND_START, rand64(), 7'd5);
        queue_tick();
        queue_tick();

        // registers changed mid-frame, later segments take the new lengths
        load_regs(16'd1, 8'd2, 8'd1, 8'd1, 8'd1, 8'd2);
        run_out();

        // an ordinary code
        queue_item(ookpw_pkg::KIND_START, rand64(), 7'd7);
        run_out();

        // zero repeats: start leaves the line idle
        load_regs(16'd1, 8'd2, 8'd1, 8'd0, 8'd1, 8'd2);
        queue_item(ookpw_pkg::KIND_START, '1, 7'd3);
        queue_tick();

        // largest pulse unit with every multiplier zero, so each segment is one tick;
        // widest code from an oversized bit count
        load_regs(16'hFFFF, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0);
        queue_item(ookpw_pkg::KIND_START, rand64(), 7'd127);
        run_out();

        // largest multiplier on the long low of a zero bit
        load_regs(16'd1, 8'd255, 8'd1, 8'd1, 8'd1, 8'd1);
        queue_item(ookpw_pkg::KIND_START, '0, 7'd1);
        run_out();

        // random part: mostly a start then a run of ticks, some noise
        for (pass_no = 0; pass_no < 6; pass_no++) begin
            load_regs(16'($urandom_range(0, 3)), 8'($urandom_range(0, 5)),
                      8'($urandom_range(0, 3)),
                      ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 3)),
                      8'($urandom_range(0, 3)), 8'($urandom_range(0, 6)));
            steady = (pass_no == 1);
            n = 0;
            while (n < 30) begin
                if ($urandom_range(0, 99) < 85) begin
                    queue_item(ookpw_pkg::KIND_START, rand64(),
                               ($urandom_range(0, 9) == 0) ? 7'($urandom)
                                                          : 7'($urandom_range(0, 10)));
                    k = $urandom_range(3, 40);
                    repeat (k) queue_tick();
                    n += k + 1;
                end else begin
                    queue_item(1'($urandom), rand64(), 7'($urandom));
                    n++;
                end
            end
            if (pass_no == 2) squeeze_arm = 1'b1;
            run_out();
            steady = 1'b0;
        end

        quiesce();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: ook_pulse_width_code_transmitter_core.f
rtl/core/ookpw_pkg.sv
rtl/core/ook_pulse_width_code_transmitter_core.sv
dv/tb_top.sv
